@@ sv/sixteen_lane_string_hash_defines.svh @@
// Assertion helpers shared by the string hash RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SIXTEEN_LANE_STRING_HASH_DEFINES_SVH
`define SIXTEEN_LANE_STRING_HASH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/slsh_pkg.sv @@
`default_nettype none

package slsh_pkg;

  localparam int LANES      = 16;
  localparam int LANE_W     = 32;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int CODE_W     = 6;
  localparam int SYM_W      = 8;
  localparam int HEX_W      = 64;
  localparam int S_DATA_W   = 8;
  localparam int M_FIELDS_W = LANE_IDX_W + LANE_W + HEX_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef logic [LANE_W-1:0]     lane_word_t;
  typedef logic [CODE_W-1:0]     sym_code_t;
  typedef logic [LANE_IDX_W-1:0] lane_idx_t;
  typedef logic [HEX_W-1:0]      hex_text_t;

  localparam logic [1:0] SHIFT_NONE  = 2'd0;
  localparam logic [1:0] SHIFT_RIGHT = 2'd1;
  localparam logic [1:0] SHIFT_LEFT  = 2'd2;

  localparam sym_code_t CODE_SPACE = 6'd62;
  localparam sym_code_t CODE_OTHER = 6'd63;

  localparam logic [1:0] LANE_SHIFT_KIND [LANES] = '{
    SHIFT_RIGHT, SHIFT_RIGHT, SHIFT_NONE,  SHIFT_LEFT,
    SHIFT_NONE,  SHIFT_RIGHT, SHIFT_LEFT,  SHIFT_LEFT,
    SHIFT_LEFT,  SHIFT_NONE,  SHIFT_LEFT,  SHIFT_NONE,
    SHIFT_LEFT,  SHIFT_NONE,  SHIFT_NONE,  SHIFT_RIGHT
  };
  localparam logic [1:0] LANE_SHIFT_AMT [LANES] = '{
    2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2,
    2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1
  };
  localparam lane_word_t LANE_MUL [LANES] = '{
    32'd41,   32'd3727, 32'd1709, 32'd491,  32'd397,  32'd383,  32'd1447, 32'd3917,
    32'd709,  32'd673,  32'd1549, 32'd859,  32'd317,  32'd2111, 32'd3449, 32'd3359
  };
  localparam lane_word_t LANE_CMUL [LANES] = '{
    32'd2467, 32'd3481, 32'd149,  32'd2999, 32'd2609, 32'd1423, 32'd1733, 32'd1667,
    32'd3821, 32'd3163, 32'd3659, 32'd727,  32'd3037, 32'd1049, 32'd3821, 32'd3011
  };
  localparam lane_word_t LANE_ADD [LANES] = '{
    32'd6337,  32'd29363, 32'd23291, 32'd11953, 32'd3907,  32'd18719, 32'd14771, 32'd26309,
    32'd31327, 32'd7717,  32'd32687, 32'd9743,  32'd22193, 32'd8951,  32'd15901, 32'd31121
  };

  // Letters, digits and space map to 0-62; everything else is 63.
  function automatic sym_code_t code_of(input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] d;
    sym_code_t        c;
    d = '0;
    c = CODE_OTHER;
    if (b inside {[8'h41:8'h5A]}) begin
      d = b - 8'h41;
      c = d[CODE_W-1:0];
    end else if (b inside {[8'h61:8'h7A]}) begin
      d = b - 8'h61 + 8'd26;
      c = d[CODE_W-1:0];
    end else if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30 + 8'd52;
      c = d[CODE_W-1:0];
    end else if (b == 8'h20) begin
      c = CODE_SPACE;
    end
    return c;
  endfunction

  // One lane update; k is a constant at every call site, so the multipliers fold.
  function automatic lane_word_t lane_next(input lane_idx_t k, input lane_word_t v,
                                           input sym_code_t code);
    lane_word_t s;
    lane_word_t cw;
    s  = '0;
    cw = {{(LANE_W-CODE_W){1'b0}}, code};
    case (LANE_SHIFT_KIND[k])
      SHIFT_RIGHT: s = v >> LANE_SHIFT_AMT[k];
      SHIFT_LEFT:  s = v << LANE_SHIFT_AMT[k];
      default:     s = '0;
    endcase
    return s + v * LANE_MUL[k] + cw * LANE_CMUL[k] + LANE_ADD[k];
  endfunction

  function automatic hex_text_t hex_of(input lane_word_t w);
    hex_text_t  t;
    logic [3:0] nib;
    t = '0;
    for (int n = 0; n < LANE_W / 4; n++) begin
      nib = w[4*n +: 4];
      t[8*n +: 8] = (nib < 4'd10) ? ({4'h0, nib} + 8'h30) : ({4'h0, nib} + 8'h37);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ sv/sixteen_lane_string_hash.sv @@
// Channel  Dir  tdata                                  tuser       tlast
// s_*      in   [7:0] symbol                           has_symbol  end_of_string
// m_*      out  [3:0] lane_index, [35:4] lane_word,    -           last
//               [99:36] hex_text, [103:100] zero
//
// Every byte with has_symbol set updates all sixteen lanes in the cycle it is accepted.
// An end-of-string transfer copies the lanes into a digest shift register and clears them.
// The digest leaves as sixteen transfers, lane 0 first. Input takes one byte per
// cycle while no digest is in flight; it stalls during the digest, except in the
// cycle the lane 15 result is taken.
// Reset (rst, synchronous) clears the lanes and drops any digest in flight.
`default_nettype none

`include "sixteen_lane_string_hash_defines.svh"

module sixteen_lane_string_hash (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  input  wire logic [slsh_pkg::S_DATA_W-1:0] s_tdata,   // symbol
  input  wire logic                         s_tuser,   // has_symbol
  input  wire logic                         s_tlast,   // end_of_string
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  output      logic [slsh_pkg::M_DATA_W-1:0] m_tdata,   // lane_index, lane_word, hex_text
  output      logic                         m_tlast    // last
);
  import slsh_pkg::*;

  logic [LANES-1:0][LANE_W-1:0] lanes;
  logic [LANES-1:0][LANE_W-1:0] lanes_upd;
  logic [LANES-1:0][LANE_W-1:0] lanes_next;
  logic [LANES-1:0][LANE_W-1:0] digest;
  logic                         busy;
  lane_idx_t                    cnt;
  sym_code_t                    code;
  logic                         in_fire;
  logic                         out_fire;
  logic                         final_beat;

  assign code       = code_of(s_tdata[SYM_W-1:0]);
  assign final_beat = (cnt == lane_idx_t'(LANES - 1));
  assign s_tready   = !busy || (m_tready && final_beat);
  assign in_fire    = s_tvalid && s_tready;
  assign out_fire   = m_tvalid && m_tready;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign lanes_upd[k] = lane_next(lane_idx_t'(k), lanes[k], code);
  end

  assign lanes_next = s_tuser ? lanes_upd : lanes;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes <= '0;
      busy  <= 1'b0;
      cnt   <= '0;
    end else begin
      if (out_fire) begin
        cnt <= cnt + lane_idx_t'(1);
        if (final_beat) begin
          busy <= 1'b0;
        end
      end
      if (in_fire) begin
        if (s_tlast) begin
          lanes <= '0;
          busy  <= 1'b1;
          cnt   <= '0;
        end else begin
          lanes <= lanes_next;
        end
      end
    end
  end

  // The digest shifts down one lane per transfer so the head is always the current result.
  always_ff @(posedge clk) begin
    if (in_fire && s_tlast) begin
      digest <= lanes_next;
    end else if (out_fire) begin
      digest <= digest >> LANE_W;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = final_beat;
  assign m_tdata  = {{(M_DATA_W-M_FIELDS_W){1'b0}}, hex_of(digest[0]), digest[0], cnt};

  `SLSH_ASSERT_NEXT(a_eos_clears, in_fire && s_tlast,
    busy && cnt == '0 && lanes == '0, "lanes not cleared at end of string")
  `SLSH_ASSERT_NOW(a_stall_in_digest, in_fire && busy,
    m_tready && final_beat, "input taken mid digest")
  `SLSH_ASSERT_NEXT(a_digest_step, out_fire && !final_beat,
    m_tvalid && cnt == $past(cnt) + lane_idx_t'(1), "digest beat lost")
  `SLSH_ASSERT_NEXT(a_digest_done, out_fire && final_beat && !(in_fire && s_tlast),
    !m_tvalid, "digest ran past lane 15")
  `SLSH_ASSERT_NEXT(a_idle_item, in_fire && !s_tuser && !s_tlast,
    $stable(lanes), "idle item changed lanes")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_CYCLES  = 300000;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_SPAN  = 300;
  localparam logic [63:0] ZERO_TEXT = 64'h3030_3030_3030_3030;

  // Per-lane update constants: shifted(v) + v * MUL + code * CMUL + ADD, all mod 2^32.
  localparam logic [1:0] LANE_SHIFT [16] = '{
    slsh_pkg::SHIFT_RIGHT, slsh_pkg::SHIFT_RIGHT, slsh_pkg::SHIFT_NONE,  slsh_pkg::SHIFT_LEFT,
    slsh_pkg::SHIFT_NONE,  slsh_pkg::SHIFT_RIGHT, slsh_pkg::SHIFT_LEFT,  slsh_pkg::SHIFT_LEFT,
    slsh_pkg::SHIFT_LEFT,  slsh_pkg::SHIFT_NONE,  slsh_pkg::SHIFT_LEFT,  slsh_pkg::SHIFT_NONE,
    slsh_pkg::SHIFT_LEFT,  slsh_pkg::SHIFT_NONE,  slsh_pkg::SHIFT_NONE,  slsh_pkg::SHIFT_RIGHT
  };
  localparam int LANE_SHAMT [16] = '{2, 2, 0, 1, 0, 3, 1, 2, 1, 0, 1, 0, 1, 0, 0, 1};
  localparam logic [31:0] WORD_MUL [16] = '{
    32'd41,  32'd3727, 32'd1709, 32'd491, 32'd397, 32'd383,  32'd1447, 32'd3917,
    32'd709, 32'd673,  32'd1549, 32'd859, 32'd317, 32'd2111, 32'd3449, 32'd3359
  };
  localparam logic [31:0] CODE_MUL [16] = '{
    32'd2467, 32'd3481, 32'd149,  32'd2999, 32'd2609, 32'd1423, 32'd1733, 32'd1667,
    32'd3821, 32'd3163, 32'd3659, 32'd727,  32'd3037, 32'd1049, 32'd3821, 32'd3011
  };
  localparam logic [31:0] WORD_ADD [16] = '{
    32'd6337,  32'd29363, 32'd23291, 32'd11953, 32'd3907,  32'd18719, 32'd14771, 32'd26309,
    32'd31327, 32'd7717,  32'd32687, 32'd9743,  32'd22193, 32'd8951,  32'd15901, 32'd31121
  };

  typedef struct packed {
    logic [3:0]  lane;
    logic [31:0] word;
    logic [63:0] text;
    logic        last;
  } lane_report_t;

  // zero_digest marks rows whose digest is known to be all-zero lanes.
  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    logic       end_of_string;
    logic       zero_digest;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0},  // idle item right after reset
    '{8'h00, 1'b0, 1'b1, 1'b1},  // empty string
    '{8'h00, 1'b0, 1'b1, 1'b1},  // empty string again
    '{8'h41, 1'b1, 1'b0, 1'b0},  // 'A'
    '{8'h5A, 1'b1, 1'b0, 1'b0},  // 'Z'
    '{8'h61, 1'b1, 1'b0, 1'b0},  // 'a'
    '{8'h7A, 1'b1, 1'b0, 1'b0},  // 'z'
    '{8'h30, 1'b1, 1'b0, 1'b0},  // '0'
    '{8'h39, 1'b1, 1'b0, 1'b0},  // '9'
    '{8'h20, 1'b1, 1'b0, 1'b0},  // space
    '{8'h00, 1'b1, 1'b0, 1'b0},  // zero byte is an ordinary byte
    '{8'hFF, 1'b1, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 1'b0},  // idle item mid-string, symbol ignored
    '{8'h40, 1'b1, 1'b0, 1'b0},  // just below 'A'
    '{8'h5B, 1'b1, 1'b0, 1'b0},  // just above 'Z'
    '{8'h60, 1'b1, 1'b0, 1'b0},  // just below 'a'
    '{8'h7B, 1'b1, 1'b0, 1'b0},  // just above 'z'
    '{8'h2F, 1'b1, 1'b0, 1'b0},  // just below '0'
    '{8'h3A, 1'b1, 1'b1, 1'b0},  // just above '9', ends the string
    '{8'h7F, 1'b1, 1'b1, 1'b0},  // one-byte string
    '{8'h55, 1'b0, 1'b1, 1'b1},  // empty string with junk symbol bits
    '{8'h00, 1'b1, 1'b1, 1'b0}   // string of a single zero byte
  };

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [slsh_pkg::S_DATA_W-1:0] s_tdata;  // symbol
  logic s_tuser;                           // has_symbol
  logic s_tlast;                           // end_of_string
  logic m_tvalid;
  logic m_tready;
  logic [slsh_pkg::M_DATA_W-1:0] m_tdata;  // lane_index, lane_word, hex_text, zero fill
  logic m_tlast;                           // last

  logic [31:0]  hash_lanes [16];
  lane_report_t pending_reports [$];
  int           error_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           stall_request;

  sixteen_lane_string_hash DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("[sixteen_lane_string_hash] ERROR");
      $finish;
    end
  end

  function automatic logic [5:0] symbol_code(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd63;
    if (b >= 8'h41 && b <= 8'h5A) d = b - 8'h41;
    else if (b >= 8'h61 && b <= 8'h7A) d = b - 8'h61 + 8'd26;
    else if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30 + 8'd52;
    else if (b == 8'h20) d = 8'd62;
    return d[5:0];
  endfunction

  function automatic logic [63:0] hex_ascii(input logic [31:0] w);
    logic [63:0] t;
    logic [3:0]  nib;
    t = '0;
    for (int n = 0; n < 8; n++) begin
      nib = w[4*n +: 4];
      t[8*n +: 8] = (nib < 4'd10) ? 8'h30 + nib : 8'h41 + (nib - 4'd10);
    end
    return t;
  endfunction

  // Advances the lane state for one accepted transfer and queues the digest it causes.
  task automatic hash_item(input logic [7:0] sym, input logic has, input logic eos,
                           input logic zero_digest);
    logic [31:0]  v;
    logic [31:0]  shifted;
    logic [31:0]  code_w;
    lane_report_t rep;
    code_w = {26'd0, symbol_code(sym)};
    if (has) begin
      for (int k = 0; k < 16; k++) begin
        v = hash_lanes[k];
        shifted = '0;
        if (LANE_SHIFT[k] == slsh_pkg::SHIFT_RIGHT) shifted = v >> LANE_SHAMT[k];
        else if (LANE_SHIFT[k] == slsh_pkg::SHIFT_LEFT) shifted = v << LANE_SHAMT[k];
        hash_lanes[k] = shifted + v * WORD_MUL[k] + code_w * CODE_MUL[k] + WORD_ADD[k];
      end
    end
    if (eos) begin
      for (int k = 0; k < 16; k++) begin
        rep.lane = k[3:0];
        rep.last = (k == 15);
        if (zero_digest) begin
          rep.word = 32'd0;
          rep.text = ZERO_TEXT;
        end else begin
          rep.word = hash_lanes[k];
          rep.text = hex_ascii(hash_lanes[k]);
        end
        pending_reports = {pending_reports, rep};
        hash_lanes[k] = '0;
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [7:0] sym, input logic has, input logic eos,
                           input logic zero_digest);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tuser  <= has;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    hash_item(sym, has, eos, zero_digest);
    @(negedge clk);
  endtask

  task automatic wait_for_digests();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
  endtask

  function automatic logic [7:0] pick_symbol();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2: b = 8'h41 + 8'($urandom_range(25));
      3, 4, 5: b = 8'h61 + 8'($urandom_range(25));
      6:       b = 8'h30 + 8'($urandom_range(9));
      7:       b = 8'h20;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Well-formed strings with random content, some idle items sprinkled in.
  task automatic send_strings(input int item_goal);
    int  sent;
    int  len;
    bit  end_on_symbol;
    sent = 0;
    while (sent < item_goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
      end_on_symbol = ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
          sent++;
        end
        send_item(pick_symbol(), 1'b1, end_on_symbol && (i == len - 1), 1'b0);
        sent++;
      end
      if (len == 0 || !end_on_symbol) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request != 0) begin
        for (int i = 0; i < stall_request; i++) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
        stall_request = 0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lane_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected output transfer: tdata %h, tlast %b", m_tdata, m_tlast);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (m_tdata[3:0] !== want.lane) begin
          $error("lane_index: expected %0d, actual %0d", want.lane, m_tdata[3:0]);
          error_count++;
        end
        if (m_tdata[35:4] !== want.word) begin
          $error("lane_word: expected %h, actual %h", want.word, m_tdata[35:4]);
          error_count++;
        end
        if (m_tdata[99:36] !== want.text) begin
          $error("hex_text: expected %h, actual %h", want.text, m_tdata[99:36]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %b, actual %b", want.last, m_tlast);
          error_count++;
        end
        if (m_tdata[slsh_pkg::M_DATA_W-1:100] !== '0) begin
          $error("tdata fill: expected 0, actual %h", m_tdata[slsh_pkg::M_DATA_W-1:100]);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tuser       <= 1'b0;
    s_tlast       <= 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 0;
    for (int k = 0; k < 16; k++) hash_lanes[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_item(DIRECTED[r].symbol, DIRECTED[r].has_symbol, DIRECTED[r].end_of_string,
                DIRECTED[r].zero_digest);
    wait_for_digests();

    send_idle_pct = 37;
    recv_idle_pct = 86;
    send_strings(116);
    wait_for_digests();

    send_idle_pct = 86;
    recv_idle_pct = 37;
    send_strings(116);
    wait_for_digests();

    // The receiver holds off while the sender offers every cycle, so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = STALL_SPAN;
    send_strings(115);
    wait_for_digests();

    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("[sixteen_lane_string_hash] OK");
    end else begin
      $display("[sixteen_lane_string_hash] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/slsh_pkg.sv
sv/sixteen_lane_string_hash.sv
test/tb_top.sv
